>>> hdl/ifbs_pkg.sv
`default_nettype none

package ifbs_pkg;

    // Field widths fixed by the item format
    localparam int DATA_W   = 32;
    localparam int FETCH_W  = 22;
    localparam int COL_W    = 10;
    localparam int ROW_W    = 9;
    localparam int KIND_W   = 2;
    localparam int BYTE_W   = 8;

    // Palette geometry
    localparam int PALETTE_DEPTH = 256;
    localparam int PAL_IDX_W     = $clog2(PALETTE_DEPTH);

    // Defaults for the top level parameters
    localparam int DEF_SCREEN_WIDTH  = 854;
    localparam int DEF_SCREEN_HEIGHT = 480;
    localparam int DEF_RAM_ADDR_BITS = 22;

    // Display enable bits and pixel format field
    localparam logic [DATA_W-1:0] CTRL_ENABLE_MASK = 32'h0000_0012;
    localparam logic [DATA_W-1:0] FORMAT_MASK      = 32'h0000_0003;

    // Bus register map
    localparam logic [DATA_W-1:0] ADDR_X_OFFSET = 32'hF000_9460;
    localparam logic [DATA_W-1:0] ADDR_WIDTH    = 32'hF000_9464;
    localparam logic [DATA_W-1:0] ADDR_Y_OFFSET = 32'hF000_9468;
    localparam logic [DATA_W-1:0] ADDR_HEIGHT   = 32'hF000_946C;
    localparam logic [DATA_W-1:0] ADDR_STRIDE   = 32'hF000_9470;
    localparam logic [DATA_W-1:0] ADDR_BASE     = 32'hF000_9474;
    localparam logic [DATA_W-1:0] ADDR_CONTROL  = 32'hF000_9480;
    localparam logic [DATA_W-1:0] ADDR_FORMAT   = 32'hF000_94B0;
    localparam logic [DATA_W-1:0] ADDR_PAL_IDX  = 32'hF000_9500;
    localparam logic [DATA_W-1:0] ADDR_PAL_DATA = 32'hF000_9504;

    typedef enum logic [1:0] {
        KIND_BUS_READ  = 2'd0,
        KIND_BUS_WRITE = 2'd1,
        KIND_FRAME     = 2'd2,
        KIND_PIXEL     = 2'd3
    } kind_t;

    typedef enum logic [3:0] {
        REG_X_OFFSET,
        REG_WIDTH,
        REG_Y_OFFSET,
        REG_HEIGHT,
        REG_STRIDE,
        REG_BASE,
        REG_CONTROL,
        REG_FORMAT,
        REG_PAL_IDX,
        REG_PAL_DATA,
        REG_NONE
    } reg_sel_t;

    // Palette memory request for one item
    typedef struct packed {
        logic                 we;
        logic                 re;
        logic [PAL_IDX_W-1:0] waddr;
        logic [PAL_IDX_W-1:0] raddr;
        logic [DATA_W-1:0]    wdata;
    } pal_req_t;

    // Result fields settled in the accept cycle; palette data joins them in the cycle after
    typedef struct packed {
        logic [DATA_W-1:0]  read_data;
        logic               read_palette;
        logic               address_known;
        logic [FETCH_W-1:0] fetch_address;
        logic               pixel_valid;
        logic [COL_W-1:0]   pixel_x;
        logic [ROW_W-1:0]   pixel_y;
        logic               frame_done;
        logic               frame_active;
    } rsp_meta_t;

    function automatic reg_sel_t decode_addr(input logic [DATA_W-1:0] a);
        reg_sel_t sel;
        sel = REG_NONE;
        unique case (a)
            ADDR_X_OFFSET: sel = REG_X_OFFSET;
            ADDR_WIDTH:    sel = REG_WIDTH;
            ADDR_Y_OFFSET: sel = REG_Y_OFFSET;
            ADDR_HEIGHT:   sel = REG_HEIGHT;
            ADDR_STRIDE:   sel = REG_STRIDE;
            ADDR_BASE:     sel = REG_BASE;
            ADDR_CONTROL:  sel = REG_CONTROL;
            ADDR_FORMAT:   sel = REG_FORMAT;
            ADDR_PAL_IDX:  sel = REG_PAL_IDX;
            ADDR_PAL_DATA: sel = REG_PAL_DATA;
            default:       sel = REG_NONE;
        endcase
        return sel;
    endfunction

endpackage

`default_nettype wire

>>> hdl/ifbs_in_if.sv
`default_nettype none

interface ifbs_in_if;
    logic                         valid;
    logic                         ready;
    logic [ifbs_pkg::KIND_W-1:0]  kind;
    logic [ifbs_pkg::DATA_W-1:0]  bus_address;
    logic [ifbs_pkg::DATA_W-1:0]  write_data;
    logic [ifbs_pkg::BYTE_W-1:0]  pixel_byte;

    modport source (output valid, kind, bus_address, write_data, pixel_byte, input ready);
    modport sink   (input valid, kind, bus_address, write_data, pixel_byte, output ready);
endinterface

`default_nettype wire

>>> hdl/ifbs_out_if.sv
`default_nettype none

interface ifbs_out_if;
    logic                          valid;
    logic                          ready;
    logic [ifbs_pkg::DATA_W-1:0]   read_data;
    logic                          address_known;
    logic [ifbs_pkg::FETCH_W-1:0]  fetch_address;
    logic                          pixel_valid;
    logic [ifbs_pkg::DATA_W-1:0]   pixel_color;
    logic [ifbs_pkg::COL_W-1:0]    pixel_x;
    logic [ifbs_pkg::ROW_W-1:0]    pixel_y;
    logic                          frame_done;
    logic                          frame_active;

    modport source (output valid, read_data, address_known, fetch_address, pixel_valid,
                    pixel_color, pixel_x, pixel_y, frame_done, frame_active,
                    input ready);
    modport sink   (input valid, read_data, address_known, fetch_address, pixel_valid,
                    pixel_color, pixel_x, pixel_y, frame_done, frame_active,
                    output ready);
endinterface

`default_nettype wire

>>> hdl/ifbs_palette_ram.sv
`default_nettype none

module ifbs_palette_ram (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire ifbs_pkg::pal_req_t          req,
    output logic [ifbs_pkg::DATA_W-1:0]      rdata
);
    import ifbs_pkg::*;

    logic [DATA_W-1:0]        mem [PALETTE_DEPTH];
    logic [PALETTE_DEPTH-1:0] written_reg;
    logic [DATA_W-1:0]        rdata_reg;
    logic                     rvalid_reg;

    // Write and registered read of the palette array
    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
        if (req.re)
        begin
            rdata_reg <= mem[req.raddr];
        end
    end

    // Track written entries; an unwritten entry reads as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            written_reg <= '0;
            rvalid_reg  <= 1'b0;
        end
        else
        begin
            if (req.we)
            begin
                written_reg[req.waddr] <= 1'b1;
            end
            if (req.re)
            begin
                rvalid_reg <= written_reg[req.raddr];
            end
        end
    end

    assign rdata = rvalid_reg ? rdata_reg : '0;

endmodule

`default_nettype wire

>>> hdl/ifbs_regfile.sv
`default_nettype none

module ifbs_regfile #(
    parameter int SCREEN_WIDTH  = ifbs_pkg::DEF_SCREEN_WIDTH,
    parameter int SCREEN_HEIGHT = ifbs_pkg::DEF_SCREEN_HEIGHT,
    parameter int RAM_ADDR_BITS = ifbs_pkg::DEF_RAM_ADDR_BITS
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        accept,
    input  wire logic [ifbs_pkg::KIND_W-1:0] kind,
    input  wire logic [ifbs_pkg::DATA_W-1:0] bus_address,
    input  wire logic [ifbs_pkg::DATA_W-1:0] write_data,
    input  wire logic [ifbs_pkg::BYTE_W-1:0] pixel_byte,
    output ifbs_pkg::pal_req_t               pal_req,
    output ifbs_pkg::rsp_meta_t              meta
);
    import ifbs_pkg::*;

    localparam int                 ADDR_BITS = (RAM_ADDR_BITS < FETCH_W) ? RAM_ADDR_BITS
                                                                           : FETCH_W;
    localparam logic [FETCH_W-1:0] ADDR_MASK = FETCH_W'((64'd1 << ADDR_BITS) - 64'd1);
    localparam logic [COL_W-1:0]   SCR_W     = COL_W'(SCREEN_WIDTH);
    localparam logic [ROW_W-1:0]   SCR_H     = ROW_W'(SCREEN_HEIGHT);

    // Bus registers
    logic [DATA_W-1:0]    x_offset_reg, width_reg, y_offset_reg, height_reg;
    logic [DATA_W-1:0]    stride_reg, control_reg, format_reg;
    logic [FETCH_W-1:0]   base_reg;
    logic [PAL_IDX_W-1:0] pal_idx_reg, pal_idx_next;

    // Scan state
    logic                 active_reg, active_next;
    logic [COL_W-1:0]     col_reg, col_next;
    logic [ROW_W-1:0]     row_reg, row_next;
    logic [FETCH_W-1:0]   row_addr_reg, row_addr_next;
    logic [FETCH_W-1:0]   pix_addr_reg, pix_addr_next;
    logic [COL_W-1:0]     fwidth_reg, fwidth_next;
    logic [ROW_W-1:0]     fheight_reg, fheight_next;
    logic [FETCH_W-1:0]   fstride_reg, fstride_next;

    kind_t                kind_c;
    reg_sel_t             sel;
    logic                 bus_wr;
    logic                 disp_on;
    logic [COL_W-1:0]     clamp_w;
    logic [ROW_W-1:0]     clamp_h;
    logic [COL_W:0]       col_inc;
    logic [ROW_W:0]       row_inc;
    logic [FETCH_W-1:0]   row_addr_inc;

    assign kind_c = kind_t'(kind);
    assign sel    = decode_addr(bus_address);
    assign bus_wr = accept && (kind_c == KIND_BUS_WRITE);

    assign disp_on = ((control_reg & CTRL_ENABLE_MASK) == CTRL_ENABLE_MASK)
                     && ((format_reg & FORMAT_MASK) == '0);
    assign clamp_w = (width_reg > DATA_W'(SCREEN_WIDTH)) ? SCR_W : width_reg[COL_W-1:0];
    assign clamp_h = (height_reg > DATA_W'(SCREEN_HEIGHT)) ? SCR_H : height_reg[ROW_W-1:0];
    assign col_inc      = {1'b0, col_reg} + 1'b1;
    assign row_inc      = {1'b0, row_reg} + 1'b1;
    assign row_addr_inc = (row_addr_reg + fstride_reg) & ADDR_MASK;

    // Decode the item: scan step, register read word, palette request
    always_comb
    begin
        active_next   = active_reg;
        col_next      = col_reg;
        row_next      = row_reg;
        row_addr_next = row_addr_reg;
        pix_addr_next = pix_addr_reg;
        fwidth_next   = fwidth_reg;
        fheight_next  = fheight_reg;
        fstride_next  = fstride_reg;
        pal_idx_next  = pal_idx_reg;
        meta          = '0;
        pal_req       = '0;
        pal_req.waddr = pal_idx_reg;
        pal_req.wdata = write_data;
        pal_req.raddr = pal_idx_reg;

        unique case (kind_c)
            KIND_BUS_READ:
            begin
                meta.address_known = (sel != REG_NONE);
                case (sel)
                    REG_X_OFFSET: meta.read_data = x_offset_reg;
                    REG_WIDTH:    meta.read_data = width_reg;
                    REG_Y_OFFSET: meta.read_data = y_offset_reg;
                    REG_HEIGHT:   meta.read_data = height_reg;
                    REG_STRIDE:   meta.read_data = stride_reg;
                    REG_BASE:     meta.read_data = DATA_W'(base_reg);
                    REG_CONTROL:  meta.read_data = control_reg;
                    REG_FORMAT:   meta.read_data = format_reg;
                    REG_PAL_IDX:  meta.read_data = DATA_W'(pal_idx_reg);
                    REG_PAL_DATA:
                    begin
                        meta.read_palette = 1'b1;
                        pal_req.re        = accept;
                    end
                    default:      meta.read_data = '0;
                endcase
            end
            KIND_BUS_WRITE:
            begin
                meta.address_known = (sel != REG_NONE);
                if (sel == REG_PAL_DATA)
                begin
                    pal_req.we   = accept;
                    pal_idx_next = pal_idx_reg + 1'b1;
                end
                else if (sel == REG_PAL_IDX)
                begin
                    pal_idx_next = write_data[PAL_IDX_W-1:0];
                end
            end
            KIND_FRAME:
            begin
                fwidth_next   = clamp_w;
                fheight_next  = clamp_h;
                fstride_next  = stride_reg[FETCH_W-1:0] & ADDR_MASK;
                row_addr_next = base_reg & ADDR_MASK;
                pix_addr_next = base_reg & ADDR_MASK;
                col_next      = '0;
                row_next      = '0;
                active_next   = disp_on && (clamp_w != '0) && (clamp_h != '0);
            end
            KIND_PIXEL:
            begin
                if (active_reg)
                begin
                    meta.pixel_valid = 1'b1;
                    meta.pixel_x     = col_reg;
                    meta.pixel_y     = row_reg;
                    pal_req.re       = accept;
                    pal_req.raddr    = pixel_byte;
                    if (col_inc >= {1'b0, fwidth_reg})
                    begin
                        col_next      = '0;
                        row_next      = row_inc[ROW_W-1:0];
                        row_addr_next = row_addr_inc;
                        pix_addr_next = row_addr_inc;
                        if (row_inc >= {1'b0, fheight_reg})
                        begin
                            active_next     = 1'b0;
                            meta.frame_done = 1'b1;
                        end
                    end
                    else
                    begin
                        col_next      = col_inc[COL_W-1:0];
                        pix_addr_next = (pix_addr_reg + 1'b1) & ADDR_MASK;
                    end
                end
            end
            default:
            begin
                active_next = active_reg;
            end
        endcase

        meta.frame_active  = active_next;
        meta.fetch_address = active_next && (kind_c == KIND_FRAME || kind_c == KIND_PIXEL)
                             ? pix_addr_next : '0;
    end

    // Update bus registers on a write item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_offset_reg <= '0;
            width_reg    <= '0;
            y_offset_reg <= '0;
            height_reg   <= '0;
            stride_reg   <= '0;
            base_reg     <= '0;
            control_reg  <= '0;
            format_reg   <= '0;
        end
        else if (bus_wr)
        begin
            case (sel)
                REG_X_OFFSET: x_offset_reg <= write_data;
                REG_WIDTH:    width_reg    <= write_data;
                REG_Y_OFFSET: y_offset_reg <= write_data;
                REG_HEIGHT:   height_reg   <= write_data;
                REG_STRIDE:   stride_reg   <= write_data;
                REG_BASE:     base_reg     <= write_data[FETCH_W-1:0] & ADDR_MASK;
                REG_CONTROL:  control_reg  <= write_data;
                REG_FORMAT:   format_reg   <= write_data;
                default:      base_reg     <= base_reg;
            endcase
        end
    end

    // Advance palette index and scan state on each accepted item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pal_idx_reg  <= '0;
            active_reg   <= 1'b0;
            col_reg      <= '0;
            row_reg      <= '0;
            row_addr_reg <= '0;
            pix_addr_reg <= '0;
            fwidth_reg   <= '0;
            fheight_reg  <= '0;
            fstride_reg  <= '0;
        end
        else if (accept)
        begin
            pal_idx_reg  <= pal_idx_next;
            active_reg   <= active_next;
            col_reg      <= col_next;
            row_reg      <= row_next;
            row_addr_reg <= row_addr_next;
            pix_addr_reg <= pix_addr_next;
            fwidth_reg   <= fwidth_next;
            fheight_reg  <= fheight_next;
            fstride_reg  <= fstride_next;
        end
    end

endmodule

`default_nettype wire

>>> hdl/indexed_framebuffer_scanout_regs.sv
// Channel   Modport          Payload
// req       ifbs_in_if.sink  kind, bus_address, write_data, pixel_byte
// rsp       ifbs_out_if.source read_data, address_known, fetch_address, pixel_valid,
//                            pixel_color, pixel_x, pixel_y, frame_done, frame_active
//
// One item per clock while the output stage is free or the result side is ready; each
// result appears in the cycle after its item is taken. The palette memory has separate read
// and write ports; its read data is registered and doubles as the output stage; register,
// scan and index updates finish at accept. Reset clears the control and scan registers and
// the palette written-entry bits; no clearing pass. A stalled result holds in the output
// stage; a new item is taken in the same cycle the held result leaves.
`default_nettype none

module indexed_framebuffer_scanout_regs #(
    parameter int SCREEN_WIDTH  = ifbs_pkg::DEF_SCREEN_WIDTH,
    parameter int SCREEN_HEIGHT = ifbs_pkg::DEF_SCREEN_HEIGHT,
    parameter int RAM_ADDR_BITS = ifbs_pkg::DEF_RAM_ADDR_BITS
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    ifbs_in_if.sink    req,
    ifbs_out_if.source rsp
);
    import ifbs_pkg::*;

    logic              accept;
    logic              out_valid_reg;
    rsp_meta_t         meta;
    rsp_meta_t         meta_reg;
    pal_req_t          pal_req;
    logic [DATA_W-1:0] pal_rdata;

    assign req.ready = !out_valid_reg || rsp.ready;
    assign accept    = req.valid && req.ready;

    ifbs_regfile #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT),
        .RAM_ADDR_BITS (RAM_ADDR_BITS)
    ) u_regfile (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .kind        (req.kind),
        .bus_address (req.bus_address),
        .write_data  (req.write_data),
        .pixel_byte  (req.pixel_byte),
        .pal_req     (pal_req),
        .meta        (meta)
    );

    ifbs_palette_ram u_palette (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (pal_req),
        .rdata (pal_rdata)
    );

    // Hold the result fields alongside the palette read
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            meta_reg <= meta;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Merge palette data into the result
    assign rsp.valid         = out_valid_reg;
    assign rsp.read_data     = meta_reg.read_palette ? pal_rdata : meta_reg.read_data;
    assign rsp.address_known = meta_reg.address_known;
    assign rsp.fetch_address = meta_reg.fetch_address;
    assign rsp.pixel_valid   = meta_reg.pixel_valid;
    assign rsp.pixel_color   = meta_reg.pixel_valid ? pal_rdata : '0;
    assign rsp.pixel_x       = meta_reg.pixel_x;
    assign rsp.pixel_y       = meta_reg.pixel_y;
    assign rsp.frame_done    = meta_reg.frame_done;
    assign rsp.frame_active  = meta_reg.frame_active;

    a_done_ends_frame: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && meta_reg.frame_done |-> !meta_reg.frame_active)
        else $error("frame_done with frame still active");

    a_fetch_only_active: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !meta_reg.frame_active |-> meta_reg.fetch_address == '0)
        else $error("fetch address outside an active frame");

    a_pixel_on_screen: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && meta_reg.pixel_valid |->
            (32'(meta_reg.pixel_x) < 32'(SCREEN_WIDTH))
            && (32'(meta_reg.pixel_y) < 32'(SCREEN_HEIGHT)))
        else $error("pixel coordinates beyond screen");

    a_pixel_not_bus: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && meta_reg.pixel_valid |->
            !meta_reg.address_known && !meta_reg.read_palette)
        else $error("pixel result mixed with bus result");

endmodule

`default_nettype wire

>>> tb/tb.sv
`timescale 1ns / 100ps

module tb;
    import ifbs_pkg::*;

    localparam logic [DATA_W-1:0] SCREEN_W = DEF_SCREEN_WIDTH;
    localparam logic [DATA_W-1:0] SCREEN_H = DEF_SCREEN_HEIGHT;
    localparam int RANDOM_ITEMS   = 120;
    localparam int STALL_LIMIT    = 2000;
    localparam int LONG_HOLD      = 64;
    localparam int MAX_REPORTS    = 40;

    typedef struct packed {
        kind_t              kind;
        logic [DATA_W-1:0]  bus_address;
        logic [DATA_W-1:0]  write_data;
        logic [BYTE_W-1:0]  pixel_byte;
    } request_t;

    typedef struct packed {
        logic [DATA_W-1:0]  read_data;
        logic               address_known;
        logic [FETCH_W-1:0] fetch_address;
        logic               pixel_valid;
        logic [DATA_W-1:0]  pixel_color;
        logic [COL_W-1:0]   pixel_x;
        logic [ROW_W-1:0]   pixel_y;
        logic               frame_done;
        logic               frame_active;
    } response_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    ifbs_in_if  req_if ();
    ifbs_out_if rsp_if ();

    indexed_framebuffer_scanout_regs dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if)
    );

    // Programmed registers as seen from the bus
    logic [DATA_W-1:0]    prog_x_offset = '0;
    logic [DATA_W-1:0]    prog_width    = '0;
    logic [DATA_W-1:0]    prog_y_offset = '0;
    logic [DATA_W-1:0]    prog_height   = '0;
    logic [DATA_W-1:0]    prog_stride   = '0;
    logic [FETCH_W-1:0]   prog_base     = '0;
    logic [DATA_W-1:0]    prog_control  = '0;
    logic [DATA_W-1:0]    prog_format   = '0;
    logic [PAL_IDX_W-1:0] pal_ptr       = '0;
    logic [DATA_W-1:0]    palette [PALETTE_DEPTH];

    // Latched frame and scan position
    logic                 scanning    = 1'b0;
    logic [COL_W-1:0]     scan_x      = '0;
    logic [ROW_W-1:0]     scan_y      = '0;
    logic [FETCH_W-1:0]   line_base   = '0;
    logic [FETCH_W-1:0]   fetch_ptr   = '0;
    logic [COL_W-1:0]     frame_w     = '0;
    logic [ROW_W-1:0]     frame_h     = '0;
    logic [FETCH_W-1:0]   frame_pitch = '0;

    response_t pending_responses [$];
    int        errors       = 0;
    int        useful_items = 0;
    int        hold_cycles  = 0;
    int        stall_count  = 0;
    bit        idle_on      = 1'b1;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Work out the response to one item and advance the shadow state
    function automatic response_t compute_response(input request_t r);
        response_t         res;
        logic [DATA_W-1:0] clamp_w;
        logic [DATA_W-1:0] clamp_h;
        res = '0;
        case (r.kind)
            KIND_BUS_READ:
            begin
                res.address_known = 1'b1;
                case (r.bus_address)
                    ADDR_X_OFFSET: res.read_data = prog_x_offset;
                    ADDR_WIDTH:    res.read_data = prog_width;
                    ADDR_Y_OFFSET: res.read_data = prog_y_offset;
                    ADDR_HEIGHT:   res.read_data = prog_height;
                    ADDR_STRIDE:   res.read_data = prog_stride;
                    ADDR_BASE:     res.read_data = {{(DATA_W-FETCH_W){1'b0}}, prog_base};
                    ADDR_CONTROL:  res.read_data = prog_control;
                    ADDR_FORMAT:   res.read_data = prog_format;
                    ADDR_PAL_IDX:  res.read_data = {{(DATA_W-PAL_IDX_W){1'b0}}, pal_ptr};
                    ADDR_PAL_DATA: res.read_data = palette[pal_ptr];
                    default:       res.address_known = 1'b0;
                endcase
            end
            KIND_BUS_WRITE:
            begin
                res.address_known = 1'b1;
                case (r.bus_address)
                    ADDR_X_OFFSET: prog_x_offset = r.write_data;
                    ADDR_WIDTH:    prog_width    = r.write_data;
                    ADDR_Y_OFFSET: prog_y_offset = r.write_data;
                    ADDR_HEIGHT:   prog_height   = r.write_data;
                    ADDR_STRIDE:   prog_stride   = r.write_data;
                    ADDR_BASE:     prog_base     = r.write_data[FETCH_W-1:0];
                    ADDR_CONTROL:  prog_control  = r.write_data;
                    ADDR_FORMAT:   prog_format   = r.write_data;
                    ADDR_PAL_IDX:  pal_ptr       = r.write_data[PAL_IDX_W-1:0];
                    ADDR_PAL_DATA:
                    begin
                        palette[pal_ptr] = r.write_data;
                        pal_ptr = pal_ptr + 1'b1;
                    end
                    default:       res.address_known = 1'b0;
                endcase
            end
            KIND_FRAME:
            begin
                clamp_w = (prog_width > SCREEN_W) ? SCREEN_W : prog_width;
                clamp_h = (prog_height > SCREEN_H) ? SCREEN_H : prog_height;
                frame_w     = clamp_w[COL_W-1:0];
                frame_h     = clamp_h[ROW_W-1:0];
                frame_pitch = prog_stride[FETCH_W-1:0];
                line_base   = prog_base;
                fetch_ptr   = prog_base;
                scan_x      = '0;
                scan_y      = '0;
                scanning    = ((prog_control & CTRL_ENABLE_MASK) == CTRL_ENABLE_MASK)
                              && ((prog_format & FORMAT_MASK) == '0)
                              && (clamp_w != '0) && (clamp_h != '0);
                if (scanning)
                    res.fetch_address = fetch_ptr;
            end
            KIND_PIXEL:
            begin
                if (scanning)
                begin
                    res.pixel_valid = 1'b1;
                    res.pixel_color = palette[r.pixel_byte];
                    res.pixel_x     = scan_x;
                    res.pixel_y     = scan_y;
                    scan_x = scan_x + 1'b1;
                    if (scan_x >= frame_w)
                    begin
                        scan_x    = '0;
                        scan_y    = scan_y + 1'b1;
                        line_base = line_base + frame_pitch;
                        fetch_ptr = line_base;
                        if (scan_y >= frame_h)
                        begin
                            scanning = 1'b0;
                            res.frame_done = 1'b1;
                        end
                    end
                    else
                        fetch_ptr = fetch_ptr + 1'b1;
                    if (scanning)
                        res.fetch_address = fetch_ptr;
                end
            end
            default:
            begin
            end
        endcase
        res.frame_active = scanning;
        return res;
    endfunction

    function automatic logic [DATA_W-1:0] reg_address(input reg_sel_t sel);
        case (sel)
            REG_X_OFFSET: return ADDR_X_OFFSET;
            REG_WIDTH:    return ADDR_WIDTH;
            REG_Y_OFFSET: return ADDR_Y_OFFSET;
            REG_HEIGHT:   return ADDR_HEIGHT;
            REG_STRIDE:   return ADDR_STRIDE;
            REG_BASE:     return ADDR_BASE;
            REG_CONTROL:  return ADDR_CONTROL;
            REG_FORMAT:   return ADDR_FORMAT;
            REG_PAL_IDX:  return ADDR_PAL_IDX;
            default:      return ADDR_PAL_DATA;
        endcase
    endfunction

    function automatic reg_sel_t any_register();
        return reg_sel_t'($urandom_range(REG_X_OFFSET, REG_PAL_DATA));
    endfunction

    // Mostly addresses off the register map: holes, near misses, anything
    function automatic logic [DATA_W-1:0] stray_address();
        case ($urandom_range(0, 3))
            0:       return $urandom;
            1:       return ADDR_BASE + 32'd4;
            2:       return ADDR_PAL_DATA + 32'd4;
            default: return reg_address(any_register()) ^ (32'd1 << $urandom_range(0, 31));
        endcase
    endfunction

    // Offer one item, wait for it to be taken, then queue its response
    task automatic send_item(input kind_t kind, input logic [DATA_W-1:0] addr,
                             input logic [DATA_W-1:0] data, input logic [BYTE_W-1:0] pix);
        request_t  r;
        response_t res;
        r.kind        = kind;
        r.bus_address = addr;
        r.write_data  = data;
        r.pixel_byte  = pix;
        if (idle_on && $urandom_range(0, 5) == 0)
        begin
            req_if.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        req_if.valid       <= 1'b1;
        req_if.kind        <= kind;
        req_if.bus_address <= addr;
        req_if.write_data  <= data;
        req_if.pixel_byte  <= pix;
        @(posedge clk);
        while (req_if.ready !== 1'b1)
            @(posedge clk);
        res = compute_response(r);
        pending_responses.push_back(res);
        if (res.address_known || res.pixel_valid || kind == KIND_FRAME)
            useful_items++;
    endtask

    task automatic bus_write(input logic [DATA_W-1:0] addr, input logic [DATA_W-1:0] data);
        send_item(KIND_BUS_WRITE, addr, data, BYTE_W'($urandom));
    endtask

    task automatic bus_read(input logic [DATA_W-1:0] addr);
        send_item(KIND_BUS_READ, addr, $urandom, BYTE_W'($urandom));
    endtask

    task automatic start_frame();
        send_item(KIND_FRAME, $urandom, $urandom, BYTE_W'($urandom));
    endtask

    task automatic send_pixel();
        send_item(KIND_PIXEL, $urandom, $urandom, BYTE_W'($urandom));
    endtask

    // Program a random geometry, start a frame and scan it, with bus traffic mixed in
    task automatic random_frame();
        logic [DATA_W-1:0] w;
        logic [DATA_W-1:0] h;
        reg_sel_t          sel;
        int unsigned       budget;
        case ($urandom_range(0, 59))
            0:
            begin
                w = $urandom | 32'h8000_0000;
                h = 32'd1;
            end
            1:
            begin
                w = 32'd1;
                h = $urandom | 32'h8000_0000;
            end
            2, 3:
            begin
                w = '0;
                h = $urandom_range(1, 6);
            end
            4, 5:
            begin
                w = $urandom_range(1, 12);
                h = '0;
            end
            6, 7, 8, 9:
            begin
                w = $urandom_range(13, 64);
                h = $urandom_range(1, 3);
            end
            default:
            begin
                w = $urandom_range(1, 12);
                h = $urandom_range(1, 6);
            end
        endcase
        bus_write(ADDR_WIDTH, w);
        bus_write(ADDR_HEIGHT, h);
        if ($urandom_range(0, 4) != 0)
            bus_write(ADDR_STRIDE, $urandom_range(0, 1) ? $urandom : $urandom_range(0, 80));
        if ($urandom_range(0, 4) != 0)
            bus_write(ADDR_BASE, $urandom);
        if ($urandom_range(0, 4) != 0)
            bus_write(ADDR_CONTROL, ($urandom_range(0, 7) == 0) ? $urandom
                                                                : ($urandom | CTRL_ENABLE_MASK));
        if ($urandom_range(0, 4) != 0)
            bus_write(ADDR_FORMAT, ($urandom_range(0, 7) == 0) ? $urandom
                                                               : ($urandom & ~FORMAT_MASK));
        if ($urandom_range(0, 3) == 0)
            bus_write(ADDR_X_OFFSET, $urandom);
        if ($urandom_range(0, 3) == 0)
            bus_write(ADDR_Y_OFFSET, $urandom);
        start_frame();

        // Scan, now and then cut short so the next frame start abandons it
        budget = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 8) : 32'hFFFF_FFFF;
        while (scanning && budget != 0)
        begin
            case ($urandom_range(0, 15))
                0: bus_read(reg_address(any_register()));
                1:
                begin
                    // keep the next geometry small
                    sel = any_register();
                    if (sel == REG_WIDTH || sel == REG_HEIGHT)
                        bus_write(reg_address(sel), $urandom_range(0, 12));
                    else
                        bus_write(reg_address(sel), $urandom);
                end
                2: send_item($urandom_range(0, 1) ? KIND_BUS_READ : KIND_BUS_WRITE,
                             stray_address(), $urandom, BYTE_W'($urandom));
                default:
                begin
                    send_pixel();
                    budget--;
                end
            endcase
        end

        // Stray pixels, a readback and an occasional item of pure noise
        repeat ($urandom_range(0, 2)) send_pixel();
        bus_read(reg_address(any_register()));
        if ($urandom_range(0, 2) == 0)
            send_item(kind_t'($urandom_range(KIND_BUS_READ, KIND_PIXEL)), stray_address(),
                      $urandom, BYTE_W'($urandom));
    endtask

    // Reset values, all-ones readback, masking, palette index wrap, unmapped addresses
    task automatic test_register_access();
        bus_read(ADDR_WIDTH);
        for (int i = REG_X_OFFSET; i <= REG_PAL_IDX; i++)
            bus_write(reg_address(reg_sel_t'(i)), 32'hFFFF_FFFF);
        for (int i = REG_X_OFFSET; i <= REG_PAL_DATA; i++)
            bus_read(reg_address(reg_sel_t'(i)));
        bus_write(ADDR_PAL_DATA, 32'hFFFF_FFFF);
        bus_read(ADDR_PAL_IDX);
        bus_read(ADDR_PAL_DATA);
        bus_write(ADDR_PAL_DATA + 32'd4, 32'hFFFF_FFFF);
        bus_read(32'h0000_0000);
        bus_read(32'hFFFF_FFFF);
    endtask

    // Blank frames, idle pixels, address wrap, restart mid-scan, writes mid-scan
    task automatic test_frame_cases();
        bus_write(ADDR_WIDTH, 32'd3);
        bus_write(ADDR_HEIGHT, 32'd2);
        bus_write(ADDR_STRIDE, 32'hFFFF_FFFE);
        send_pixel();
        start_frame();
        bus_write(ADDR_FORMAT, 32'hFFFF_FFFC);
        start_frame();
        repeat (3) send_pixel();
        bus_write(ADDR_WIDTH, 32'd1);
        repeat (3) send_pixel();
        send_pixel();
        bus_write(ADDR_CONTROL, 32'h0000_0010);
        start_frame();
        bus_write(ADDR_CONTROL, CTRL_ENABLE_MASK);
        bus_write(ADDR_HEIGHT, 32'd0);
        start_frame();
        bus_write(ADDR_HEIGHT, 32'd2);
        start_frame();
        send_pixel();
        start_frame();
        send_pixel();
    endtask

    // Fill the whole palette through the auto-incrementing index, then spot-check
    task automatic test_palette_load();
        bus_write(ADDR_PAL_IDX, $urandom);
        repeat (PALETTE_DEPTH + 1) bus_write(ADDR_PAL_DATA, $urandom);
        repeat (8)
        begin
            bus_write(ADDR_PAL_IDX, $urandom);
            bus_read(ADDR_PAL_DATA);
            bus_read(ADDR_PAL_DATA);
            bus_read(ADDR_PAL_IDX);
        end
    endtask

    // Widest clamped row and tallest clamped column
    task automatic test_full_size_frames();
        bus_write(ADDR_CONTROL, CTRL_ENABLE_MASK);
        bus_write(ADDR_FORMAT, '0);
        bus_write(ADDR_WIDTH, 32'hFFFF_FFFF);
        bus_write(ADDR_HEIGHT, 32'd1);
        bus_write(ADDR_STRIDE, $urandom);
        bus_write(ADDR_BASE, 32'h003F_FF00);
        start_frame();
        while (scanning)
            send_pixel();
        bus_write(ADDR_WIDTH, 32'd1);
        bus_write(ADDR_HEIGHT, 32'h8000_0000);
        bus_write(ADDR_STRIDE, 32'hFFFF_FFFF);
        start_frame();
        while (scanning)
            send_pixel();
    endtask

    // Hold the result side off for a long stretch while items keep coming
    task automatic test_backpressure();
        hold_cycles = LONG_HOLD;
        random_frame();
        random_frame();
    endtask

    task automatic test_random_traffic();
        int goal;
        goal = useful_items + RANDOM_ITEMS;
        while (useful_items < goal)
        begin
            idle_on = (useful_items < goal - RANDOM_ITEMS / 10) && ($urandom_range(0, 3) != 0);
            random_frame();
        end
    endtask

    initial
    begin
        rst_n              <= 1'b0;
        req_if.valid       <= 1'b0;
        req_if.kind        <= KIND_BUS_READ;
        req_if.bus_address <= '0;
        req_if.write_data  <= '0;
        req_if.pixel_byte  <= '0;
        for (int i = 0; i < PALETTE_DEPTH; i++)
            palette[i] = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        test_register_access();
        test_frame_cases();
        test_palette_load();
        test_full_size_frames();
        test_backpressure();
        test_random_traffic();
        req_if.valid <= 1'b0;

        // Drain outstanding responses, then let the output stage settle
        while (pending_responses.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // Result side: random short stalls, or one long hold when asked
    initial
    begin
        rsp_if.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (hold_cycles != 0)
            begin
                rsp_if.ready <= 1'b0;
                repeat (hold_cycles) @(posedge clk);
                hold_cycles = 0;
                rsp_if.ready <= 1'b1;
            end
            else if (idle_on && $urandom_range(0, 5) == 0)
            begin
                rsp_if.ready <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge clk);
                rsp_if.ready <= 1'b1;
            end
            else
                rsp_if.ready <= 1'b1;
        end
    end

    task automatic check_field(input string name, input logic [DATA_W-1:0] want,
                               input logic [DATA_W-1:0] got);
        if (want !== got)
        begin
            if (errors < MAX_REPORTS)
                $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
            errors++;
        end
    endtask

    // Compare each delivered result with the oldest pending response
    always @(posedge clk)
    begin : compare_results
        response_t want;
        if (rst_n === 1'b1 && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1)
        begin
            if (pending_responses.size() == 0)
            begin
                if (errors < MAX_REPORTS)
                    $display("%0t: unexpected result: expected none, actual read_data %h color %h",
                             $time, rsp_if.read_data, rsp_if.pixel_color);
                errors++;
            end
            else
            begin
                want = pending_responses.pop_front();
                check_field("read_data", want.read_data, rsp_if.read_data);
                check_field("address_known", want.address_known, rsp_if.address_known);
                check_field("fetch_address", want.fetch_address, rsp_if.fetch_address);
                check_field("pixel_valid", want.pixel_valid, rsp_if.pixel_valid);
                check_field("pixel_color", want.pixel_color, rsp_if.pixel_color);
                check_field("pixel_x", want.pixel_x, rsp_if.pixel_x);
                check_field("pixel_y", want.pixel_y, rsp_if.pixel_y);
                check_field("frame_done", want.frame_done, rsp_if.frame_done);
                check_field("frame_active", want.frame_active, rsp_if.frame_active);
            end
        end
    end

    // Abort when neither side has moved an item for too long
    always @(posedge clk)
    begin
        if ((req_if.valid === 1'b1 && req_if.ready === 1'b1)
            || (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1))
            stall_count = 0;
        else
            stall_count++;
        if (stall_count >= STALL_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

endmodule

>>> indexed_framebuffer_scanout_regs.f
hdl/ifbs_pkg.sv
hdl/ifbs_in_if.sv
hdl/ifbs_out_if.sv
hdl/ifbs_palette_ram.sv
hdl/ifbs_regfile.sv
hdl/indexed_framebuffer_scanout_regs.sv
tb/tb.sv
